/* rtl/rgr_pkg.sv */
// Package for the rotated glyph rasterizer: sizing constants, register indexes,
// configuration and row-descriptor types, fixed-point helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgr_pkg;

    localparam int MAX_COLUMNS   = 32;
    localparam int FRACTION_BITS = 14;
    localparam int Q_BITS        = 14;
    localparam int ROW_BITS_W    = 32;
    localparam int COL_LIMIT     = (MAX_COLUMNS < ROW_BITS_W) ? MAX_COLUMNS : ROW_BITS_W;
    localparam int COL_W         = 6;
    localparam int POS_W         = 32;
    localparam int SHIFT_UP      = (FRACTION_BITS >= Q_BITS) ? FRACTION_BITS - Q_BITS : 0;
    localparam int SHIFT_DN      = (FRACTION_BITS >= Q_BITS) ? 0 : Q_BITS - FRACTION_BITS;
    localparam int ROW_FIFO_DEPTH = 2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XMIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_XMAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YMIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YMAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE   = 3'd6;

    typedef struct packed {
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
        logic signed [15:0] clip_x_min;
        logic signed [15:0] clip_x_max;
        logic signed [15:0] clip_y_min;
        logic signed [15:0] clip_y_max;
        logic        [15:0] page_length;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0]      base_x;
        logic signed [POS_W-1:0]      base_y;
        logic signed [15:0]           pen_x;
        logic signed [15:0]           pen_y;
        logic        [COL_W-1:0]      ncol;
        logic        [ROW_BITS_W-1:0] bits;
        logic                         final_row;
    } t_row;

    // Q1.14 to position format; dropped bits are floored
    function automatic logic signed [POS_W-1:0] to_pos(input logic signed [15:0] v);
        logic signed [POS_W-1:0] w;
        w = POS_W'(v);
        return (w <<< SHIFT_UP) >>> SHIFT_DN;
    endfunction

endpackage

`default_nettype wire

/* rtl/rotated_glyph_rasterizer.sv */
// Rotated glyph rasterizer: draws glyph bitmap rows along a text angle and
// clips the lit points. Top level; depends on rgr_pkg, rgr_front, rgr_fifo, rgr_back.
//
// Input channel: push/full. One transfer carries one bitmap row, leftmost
// column in bit 31. first_row loads the base position and advanced pen;
// final_row adds the pen update after the row's points.
// Result channel: empty/pop. Each transfer is one lit point or the pen update;
// last marks the final result of a row. A row that lights nothing and is not
// final gives no result.
// Configuration: i_cfg_valid/o_cfg_ready, always ready; write only while idle.
// Path: a row passes the front-end register stage and the queue before the
// column walker takes it; its first result is registered as the walker passes
// the second lit point, or else by the flush after the row's last column.
// Row walk: the walker steps through column_count (at most 32) columns of a row
// and takes no new row until done; it also waits on a full output register.
// Reset clears the pipeline, the queue and the glyph state, and loads the
// register defaults. When the receiver stalls, the walker stops at the next
// point to emit, then the queue fills and full rises.
`timescale 1ns / 1ps
`default_nettype none

module rotated_glyph_rasterizer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [2:0]          i_cfg_index,
    input  wire  [15:0]         i_cfg_data,
    input  wire                 push,
    output logic                full,
    input  wire                 i_first_row,
    input  wire                 i_final_row,
    input  wire signed [15:0]   i_pen_x,
    input  wire signed [15:0]   i_pen_y,
    input  wire signed [7:0]    i_glyph_left,
    input  wire signed [7:0]    i_glyph_up,
    input  wire        [7:0]    i_advance_width,
    input  wire        [5:0]    i_column_count,
    input  wire        [31:0]   i_row_bits,
    output logic                empty,
    input  wire                 pop,
    output logic signed [15:0]  o_out_x,
    output logic signed [17:0]  o_out_y,
    output logic                o_is_pen_update,
    output logic                o_last
);
    rgr_pkg::t_cfg r_cfg;
    rgr_pkg::t_row w_q_in, w_q_out;
    logic          w_q_push, w_q_full, w_q_pop, w_q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_q14     <= 16'sd16384;
            r_cfg.sin_q14     <= '0;
            r_cfg.clip_x_min  <= 16'sh8000;
            r_cfg.clip_x_max  <= 16'sh7FFF;
            r_cfg.clip_y_min  <= 16'sh8000;
            r_cfg.clip_y_max  <= 16'sh7FFF;
            r_cfg.page_length <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rgr_pkg::REG_COS:  r_cfg.cos_q14     <= i_cfg_data;
                rgr_pkg::REG_SIN:  r_cfg.sin_q14     <= i_cfg_data;
                rgr_pkg::REG_XMIN: r_cfg.clip_x_min  <= i_cfg_data;
                rgr_pkg::REG_XMAX: r_cfg.clip_x_max  <= i_cfg_data;
                rgr_pkg::REG_YMIN: r_cfg.clip_y_min  <= i_cfg_data;
                rgr_pkg::REG_YMAX: r_cfg.clip_y_max  <= i_cfg_data;
                rgr_pkg::REG_PAGE: r_cfg.page_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rgr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_push          (push),
        .o_full          (full),
        .i_first_row     (i_first_row),
        .i_final_row     (i_final_row),
        .i_pen_x         (i_pen_x),
        .i_pen_y         (i_pen_y),
        .i_glyph_left    (i_glyph_left),
        .i_glyph_up      (i_glyph_up),
        .i_advance_width (i_advance_width),
        .i_column_count  (i_column_count),
        .i_row_bits      (i_row_bits),
        .i_q_full        (w_q_full),
        .o_q_push        (w_q_push),
        .o_q_data        (w_q_in)
    );

    rgr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    rgr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_empty       (w_q_empty),
        .i_q_data        (w_q_out),
        .o_q_pop         (w_q_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_is_pen_update (o_is_pen_update),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

/* rtl/rgr_fifo.sv */
// Short row-descriptor queue between the front and back ends.
// Depends on rgr_pkg (t_row, ROW_FIFO_DEPTH).
`timescale 1ns / 1ps
`default_nettype none

module rgr_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  rgr_pkg::t_row    i_data,
    output logic             o_full,
    input  wire              i_pop,
    output rgr_pkg::t_row    o_data,
    output logic             o_empty
);
    localparam int PTR_W = $clog2(rgr_pkg::ROW_FIFO_DEPTH);
    localparam int CNT_W = $clog2(rgr_pkg::ROW_FIFO_DEPTH + 1);

    rgr_pkg::t_row    r_mem [rgr_pkg::ROW_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(rgr_pkg::ROW_FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/rgr_front.sv */
// Front end: accepts glyph rows, computes the rotated base and advanced pen,
// keeps the per-glyph state and hands row descriptors to the queue.
// Depends on rgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgr_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rgr_pkg::t_cfg       i_cfg,
    input  wire                 i_push,
    output logic                o_full,
    input  wire                 i_first_row,
    input  wire                 i_final_row,
    input  wire signed [15:0]   i_pen_x,
    input  wire signed [15:0]   i_pen_y,
    input  wire signed [7:0]    i_glyph_left,
    input  wire signed [7:0]    i_glyph_up,
    input  wire        [7:0]    i_advance_width,
    input  wire        [5:0]    i_column_count,
    input  wire        [31:0]   i_row_bits,
    input  wire                 i_q_full,
    output logic                o_q_push,
    output rgr_pkg::t_row       o_q_data
);
    localparam int PW = rgr_pkg::POS_W;

    logic                  r_s1_valid;
    logic                  r_first;
    logic                  r_final;
    logic signed [15:0]    r_pen_x;
    logic signed [15:0]    r_pen_y;
    logic [rgr_pkg::COL_W-1:0] r_ncol;
    logic [31:0]           r_bits;
    logic signed [PW-1:0]  r_cl, r_su, r_sl, r_cu, r_ca, r_sa;
    logic signed [PW-1:0]  r_base_x, r_base_y;
    logic signed [15:0]    r_next_pen_x, r_next_pen_y;

    logic signed [PW-1:0]  w_cp, w_sp, w_adv;
    logic                  w_accept, w_go;
    logic signed [PW-1:0]  w_ld_x, w_ld_y, w_row_x, w_row_y;
    logic signed [PW-1:0]  w_pen_sx, w_pen_sy;
    logic signed [15:0]    w_new_pen_x, w_new_pen_y, w_row_pen_x, w_row_pen_y;
    logic [rgr_pkg::COL_W-1:0] w_ncol;

    function automatic logic signed [15:0] trunc_q(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v >>> rgr_pkg::Q_BITS;
        if (v[PW-1] && (v[rgr_pkg::Q_BITS-1:0] != '0)) begin
            t = t + PW'(1);
        end
        return t[15:0];
    endfunction

    assign w_cp  = rgr_pkg::to_pos(i_cfg.cos_q14);
    assign w_sp  = rgr_pkg::to_pos(i_cfg.sin_q14);
    assign w_adv = $signed({{(PW-8){1'b0}}, i_advance_width});

    assign o_full   = r_s1_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign w_go     = r_s1_valid && !i_q_full;
    assign w_ncol   = (i_column_count > rgr_pkg::COL_W'(rgr_pkg::COL_LIMIT))
                    ? rgr_pkg::COL_W'(rgr_pkg::COL_LIMIT) : i_column_count;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= i_first_row;
            r_final <= i_final_row;
            r_pen_x <= i_pen_x;
            r_pen_y <= i_pen_y;
            r_ncol  <= w_ncol;
            r_bits  <= i_row_bits;
            r_cl    <= w_cp * PW'(i_glyph_left);
            r_su    <= w_sp * PW'(i_glyph_up);
            r_sl    <= w_sp * PW'(i_glyph_left);
            r_cu    <= w_cp * PW'(i_glyph_up);
            r_ca    <= PW'(i_cfg.cos_q14) * w_adv;
            r_sa    <= PW'(i_cfg.sin_q14) * w_adv;
        end
    end

    assign w_ld_x      = (PW'(r_pen_x) <<< rgr_pkg::FRACTION_BITS) - r_cl - r_su;
    assign w_ld_y      = (PW'(r_pen_y) <<< rgr_pkg::FRACTION_BITS) - r_sl + r_cu;
    assign w_pen_sx    = (PW'(r_pen_x) <<< rgr_pkg::Q_BITS) + r_ca;
    assign w_pen_sy    = (PW'(r_pen_y) <<< rgr_pkg::Q_BITS) + r_sa;
    assign w_new_pen_x = trunc_q(w_pen_sx);
    assign w_new_pen_y = trunc_q(w_pen_sy);
    assign w_row_x     = r_first ? w_ld_x : r_base_x;
    assign w_row_y     = r_first ? w_ld_y : r_base_y;
    assign w_row_pen_x = r_first ? w_new_pen_x : r_next_pen_x;
    assign w_row_pen_y = r_first ? w_new_pen_y : r_next_pen_y;

    assign o_q_push = w_go;
    always_comb begin
        o_q_data.base_x    = w_row_x;
        o_q_data.base_y    = w_row_y;
        o_q_data.pen_x     = w_row_pen_x;
        o_q_data.pen_y     = w_row_pen_y;
        o_q_data.ncol      = r_ncol;
        o_q_data.bits      = r_bits;
        o_q_data.final_row = r_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_base_x     <= '0;
            r_base_y     <= '0;
            r_next_pen_x <= '0;
            r_next_pen_y <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_go) begin
                r_base_x     <= w_row_x + w_sp;
                r_base_y     <= w_row_y - w_cp;
                r_next_pen_x <= w_row_pen_x;
                r_next_pen_y <= w_row_pen_y;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/rgr_back.sv */
// Back end: walks the columns of one row descriptor, clips and emits points,
// then, for a final row, the pen update; holds one point back so the row's last result is marked.
// Depends on rgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rgr_pkg::t_cfg       i_cfg,
    input  wire                 i_q_empty,
    input  rgr_pkg::t_row       i_q_data,
    output logic                o_q_pop,
    output logic                o_empty,
    input  wire                 i_pop,
    output logic signed [15:0]  o_out_x,
    output logic signed [17:0]  o_out_y,
    output logic                o_is_pen_update,
    output logic                o_last
);
    localparam int PW = rgr_pkg::POS_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH, ST_PEN} t_state;

    t_state                    r_state;
    logic signed [PW-1:0]      r_px, r_py;
    logic [31:0]               r_bits;
    logic [rgr_pkg::COL_W-1:0] r_col, r_ncol;
    logic                      r_final;
    logic signed [15:0]        r_pen_x, r_pen_y;
    logic                      r_pend_valid;
    logic signed [15:0]        r_pend_x;
    logic signed [17:0]        r_pend_y;
    logic                      r_out_valid;

    logic signed [PW-1:0]      w_cp, w_sp, w_ix, w_iy;
    logic signed [PW:0]        w_fy;
    logic                      w_hit, w_out_free, w_stall, w_row_done, w_emit;

    function automatic logic signed [PW-1:0] trunc_pix(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v >>> rgr_pkg::FRACTION_BITS;
        if (v[PW-1] && (v[rgr_pkg::FRACTION_BITS-1:0] != '0)) begin
            t = t + PW'(1);
        end
        return t;
    endfunction

    assign w_cp = rgr_pkg::to_pos(i_cfg.cos_q14);
    assign w_sp = rgr_pkg::to_pos(i_cfg.sin_q14);
    assign w_ix = trunc_pix(r_px);
    assign w_iy = trunc_pix(r_py);
    assign w_fy = $signed({{(PW-15){1'b0}}, i_cfg.page_length}) - (PW+1)'(w_iy);

    assign w_hit = r_bits[31]
                && (w_ix > PW'(i_cfg.clip_x_min)) && (w_ix < PW'(i_cfg.clip_x_max))
                && (w_iy > PW'(i_cfg.clip_y_min)) && (w_iy < PW'(i_cfg.clip_y_max));

    assign w_out_free = !r_out_valid || i_pop;
    assign w_row_done = (r_col == r_ncol);
    assign w_stall    = w_hit && r_pend_valid && !w_out_free;
    assign w_emit     = ((r_state == ST_SCAN) && !w_row_done && !w_stall && w_hit
                         && r_pend_valid)
                     || ((r_state == ST_FLUSH) && r_pend_valid && w_out_free)
                     || ((r_state == ST_PEN) && w_out_free);
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_empty    = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_px    <= i_q_data.base_x;
                        r_py    <= i_q_data.base_y;
                        r_bits  <= i_q_data.bits;
                        r_ncol  <= i_q_data.ncol;
                        r_col   <= '0;
                        r_final <= i_q_data.final_row;
                        r_pen_x <= i_q_data.pen_x;
                        r_pen_y <= i_q_data.pen_y;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_row_done) begin
                        r_state <= ST_FLUSH;
                    end else if (!w_stall) begin
                        r_px   <= r_px + w_cp;
                        r_py   <= r_py + w_sp;
                        r_bits <= {r_bits[30:0], 1'b0};
                        r_col  <= r_col + 1'b1;
                        if (w_hit) begin
                            if (r_pend_valid) begin
                                o_out_x         <= r_pend_x;
                                o_out_y         <= r_pend_y;
                                o_is_pen_update <= 1'b0;
                                o_last          <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_x     <= w_ix[15:0];
                            r_pend_y     <= w_fy[17:0];
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= r_final ? ST_PEN : ST_IDLE;
                    end else if (w_out_free) begin
                        o_out_x         <= r_pend_x;
                        o_out_y         <= r_pend_y;
                        o_is_pen_update <= 1'b0;
                        o_last          <= !r_final;
                        r_pend_valid    <= 1'b0;
                        r_state         <= r_final ? ST_PEN : ST_IDLE;
                    end
                end
                ST_PEN: begin
                    if (w_out_free) begin
                        o_out_x         <= r_pen_x;
                        o_out_y         <= 18'(r_pen_y);
                        o_is_pen_update <= 1'b1;
                        o_last          <= 1'b1;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_pen_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_is_pen_update) |-> o_last)
        else $error("pen update not marked last");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held point left over at row end");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_col <= r_ncol))
        else $error("column index past row length");

    a_pop_starts_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == ST_SCAN) && (r_col == '0))
        else $error("row fetch did not start a scan");

endmodule

`default_nettype wire
